@@ hdl/prs_pkg.sv @@
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the priority round-robin scheduler.
// ----------------------------------------------------------------------------
package prs_pkg;

	localparam int PRS_CHANNELS = 32;
	localparam int PRS_LEVELS   = 8;

	localparam int ACTION_W  = 2;
	localparam int CHANNEL_W = 5;
	localparam int LEVEL_W   = 3;
	localparam int LIU_W     = 4;

	localparam logic [LIU_W-1:0] LIU_RESET = 4'd8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_REQ_CTRL = 2'd0,
		ACT_REQ_DATA = 2'd1,
		ACT_POP_CTRL = 2'd2,
		ACT_POP_DATA = 2'd3
	} action_t;

	// command handed from the input stage to the request bank
	typedef struct packed {
		logic                 en;
		logic                 pop;
		logic                 cls;
		logic [CHANNEL_W-1:0] channel;
		logic [LEVEL_W-1:0]   level;
	} prs_cmd_t;

	typedef struct packed {
		logic                 granted;
		logic [CHANNEL_W-1:0] channel;
	} prs_grant_t;

endpackage

@@ hdl/prs_channels.sv @@
// ----------------------------------------------------------------------------
// prs_channels
// Valid/ready channel interfaces: request/pop items, grant results, config.
// ----------------------------------------------------------------------------
interface prs_item_if;
	import prs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ACTION_W-1:0]  action;
	logic [CHANNEL_W-1:0] channel;
	logic [LEVEL_W-1:0]   level;

	modport source (output valid, action, channel, level, input ready);
	modport sink   (input valid, action, channel, level, output ready);
endinterface

interface prs_result_if;
	import prs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 granted;
	logic [CHANNEL_W-1:0] granted_channel;

	modport source (output valid, granted, granted_channel, input ready);
	modport sink   (input valid, granted, granted_channel, output ready);
endinterface

interface prs_cfg_if;
	import prs_pkg::*;
	logic             valid;
	logic             ready;
	logic [LIU_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

@@ hdl/prs_rr_pick.sv @@
// ----------------------------------------------------------------------------
// prs_rr_pick
// Round-robin priority encoder: lowest set bit above the last grant, else
// the lowest set bit.
// ----------------------------------------------------------------------------
module prs_rr_pick #(
	parameter int CHANNELS = prs_pkg::PRS_CHANNELS
) (
	input  logic [CHANNELS-1:0]         set,
	input  logic [$clog2(CHANNELS)-1:0] last,
	output logic                        found,
	output logic [$clog2(CHANNELS)-1:0] pick
);
	localparam int CW = $clog2(CHANNELS);

	logic          any_above;
	logic [CW-1:0] pick_above;
	logic [CW-1:0] pick_low;

	always_comb begin
		any_above  = 1'b0;
		pick_above = '0;
		pick_low   = '0;
		// scan downward so the lowest hit is the one kept
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (set[i]) begin
				pick_low = CW'(i);
				if (i > int'(last)) begin
					pick_above = CW'(i);
					any_above  = 1'b1;
				end
			end
		end
	end

	assign found = |set;
	assign pick  = any_above ? pick_above : pick_low;

endmodule

@@ hdl/prs_bank.sv @@
// ----------------------------------------------------------------------------
// prs_bank
// Pending request bitmaps and last-grant pointers per class and level;
// applies one request or pop per cycle while enabled and returns the grant.
// ----------------------------------------------------------------------------
module prs_bank #(
	parameter int CHANNELS = prs_pkg::PRS_CHANNELS,
	parameter int LEVELS   = prs_pkg::PRS_LEVELS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  prs_pkg::prs_cmd_t          cmd,
	input  logic [prs_pkg::LIU_W-1:0]  levels_in_use,
	output prs_pkg::prs_grant_t        grant
);
	import prs_pkg::*;

	localparam int CW  = $clog2(CHANNELS);
	localparam int LIW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic [CHANNELS-1:0] pend_q [2][LEVELS];
	logic [CW-1:0]       last_q [2][LEVELS];

	logic                sel_found;
	logic [LIW-1:0]      sel_lv;
	logic [CHANNELS-1:0] sel_set;
	logic [CW-1:0]       sel_last;
	logic                rr_found;
	logic [CW-1:0]       rr_pick;
	logic                req_ok;
	logic [LIW-1:0]      req_lv;
	logic [CW-1:0]       req_ch;

	// first non-empty level within the scanned range
	always_comb begin
		sel_found = 1'b0;
		sel_lv    = '0;
		for (int lv = LEVELS - 1; lv >= 0; lv--) begin
			if (lv < int'(levels_in_use) && (|pend_q[cmd.cls][lv])) begin
				sel_found = 1'b1;
				sel_lv    = LIW'(lv);
			end
		end
	end

	assign sel_set  = pend_q[cmd.cls][sel_lv];
	assign sel_last = last_q[cmd.cls][sel_lv];

	prs_rr_pick #(.CHANNELS(CHANNELS)) u_pick (
		.set   (sel_set),
		.last  (sel_last),
		.found (rr_found),
		.pick  (rr_pick)
	);

	// drop requests outside the configured channel or level range
	assign req_ok = (int'(cmd.channel) < CHANNELS) && (int'(cmd.level) < LEVELS);
	assign req_lv = LIW'(cmd.level);
	assign req_ch = CW'(cmd.channel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				for (int lv = 0; lv < LEVELS; lv++) begin
					pend_q[c][lv] <= '0;
					last_q[c][lv] <= '0;
				end
			end
		end else if (cmd.en) begin
			if (!cmd.pop) begin
				if (req_ok) begin
					pend_q[cmd.cls][req_lv][req_ch] <= 1'b1;
				end
			end else if (sel_found && rr_found) begin
				pend_q[cmd.cls][sel_lv][rr_pick] <= 1'b0;
				last_q[cmd.cls][sel_lv]          <= rr_pick;
			end
		end
	end

	assign grant.granted = sel_found && rr_found;
	assign grant.channel = (sel_found && rr_found) ? CHANNEL_W'(rr_pick) : '0;

endmodule

@@ hdl/priority_round_robin_scheduler.sv @@
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler
// Strict-priority, round-robin transmit scheduler for two traffic classes.
// ----------------------------------------------------------------------------
// Usage:
//   item   : request (control/data, channel, level) or pop (control/data).
//            A request adds the channel to its class/level set and gives
//            no result; a pop gives exactly one result item.
//   result : granted flag and granted channel (zero when nothing granted).
//   cfg    : levels_in_use, number of levels a pop scans, level 0 first.
//            Write only while the scheduler is idle.
// Timing:
//   One item per cycle sustained unless a pop is held by a waiting result.
//   An item goes into the input register on acceptance; the grant decision
//   and set update are made from that register, and a pop's result is
//   registered as the pop leaves it. The combinational decision is the
//   level scan plus the CHANNELS-bit round-robin encoder.
// Reset:
//   All request sets empty, all pointers zero, levels_in_use = 8.
// Stall:
//   While a result waits, requests keep flowing; a pop holds in the input
//   register and item.ready drops until the result register frees up.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler #(
	parameter int CHANNELS = prs_pkg::PRS_CHANNELS,
	parameter int LEVELS   = prs_pkg::PRS_LEVELS
) (
	input  logic         clk,
	input  logic         arst_n,
	prs_item_if.sink     item,
	prs_result_if.source result,
	prs_cfg_if.sink      cfg
);
	import prs_pkg::*;

	logic                 v_s1;
	logic [ACTION_W-1:0]  act_s1;
	logic [CHANNEL_W-1:0] chan_s1;
	logic [LEVEL_W-1:0]   lvl_s1;

	logic                 out_v_q;
	logic                 out_granted_q;
	logic [CHANNEL_W-1:0] out_chan_q;

	logic [LIU_W-1:0]     liu_q;

	logic                 pop_s1;
	logic                 adv_s1;
	prs_cmd_t             cmd;
	prs_grant_t           grant;

	assign pop_s1 = (act_s1 == ACT_POP_CTRL) || (act_s1 == ACT_POP_DATA);
	// a request never needs the result register
	assign adv_s1 = v_s1 && (!pop_s1 || !out_v_q || result.ready);

	assign item.ready = !v_s1 || adv_s1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			act_s1  <= item.action;
			chan_s1 <= item.channel;
			lvl_s1  <= item.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			liu_q <= LIU_RESET;
		end else if (cfg.valid) begin
			liu_q <= cfg.data;
		end
	end

	assign cmd.en      = adv_s1;
	assign cmd.pop     = pop_s1;
	assign cmd.cls     = (act_s1 == ACT_REQ_DATA) || (act_s1 == ACT_POP_DATA);
	assign cmd.channel = chan_s1;
	assign cmd.level   = lvl_s1;

	prs_bank #(.CHANNELS(CHANNELS), .LEVELS(LEVELS)) u_bank (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.levels_in_use (liu_q),
		.grant         (grant)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1 && pop_s1) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pop_s1) begin
			out_granted_q <= grant.granted;
			out_chan_q    <= grant.channel;
		end
	end

	assign result.valid           = out_v_q;
	assign result.granted         = out_granted_q;
	assign result.granted_channel = out_chan_q;

endmodule
